### design/pfc_pkg.sv
package pfc_pkg;

  // geometry, bank and sector sizes are powers of two
  localparam int unsigned BANK_BYTES   = 65536;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned NUM_BANKS    = 2;

  localparam int unsigned STORE_BYTES = BANK_BYTES * NUM_BANKS;
  localparam int unsigned BANK_AW     = $clog2(BANK_BYTES);
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;

  // erase extents, clipped to bank and store
  localparam int unsigned SECT_LEN    = (SECTOR_BYTES > BANK_BYTES) ? BANK_BYTES : SECTOR_BYTES;
  localparam int unsigned CHIP_LEN_S  = BANK_BYTES;
  localparam int unsigned CHIP_LEN_L  = (2 * BANK_BYTES > STORE_BYTES) ? STORE_BYTES
                                                                       : 2 * BANK_BYTES;
  localparam logic [STORE_AW-1:0] SECT_LAST   = STORE_AW'(SECT_LEN - 1);
  localparam logic [STORE_AW-1:0] CHIP_LAST_S = STORE_AW'(CHIP_LEN_S - 1);
  localparam logic [STORE_AW-1:0] CHIP_LAST_L = STORE_AW'(CHIP_LEN_L - 1);
  localparam logic [STORE_AW-1:0] STORE_LAST  = STORE_AW'(STORE_BYTES - 1);
  localparam logic                BANK_MASK   = 1'(NUM_BANKS - 1);

  // bus command sequence
  localparam logic [ADDR_W-1:0] ADDR_CMD      = 16'h5555;
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK   = 16'h2AAA;
  localparam logic [ADDR_W-1:0] ADDR_BANK     = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_ID_MFR   = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_ID_DEV   = 16'h0001;
  localparam logic [DATA_W-1:0] DATA_UNLOCK1  = 8'hAA;
  localparam logic [DATA_W-1:0] DATA_UNLOCK2  = 8'h55;
  localparam logic [DATA_W-1:0] CMD_ID_ENTER  = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT   = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
  localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_BANK      = 8'hB0;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERS  = 8'h10;
  localparam logic [DATA_W-1:0] CMD_SECT_ERS  = 8'h30;
  localparam logic [DATA_W-1:0] ID_MFR_S      = 8'h32;
  localparam logic [DATA_W-1:0] ID_DEV_S      = 8'h1B;
  localparam logic [DATA_W-1:0] ID_MFR_L      = 8'h62;
  localparam logic [DATA_W-1:0] ID_DEV_L      = 8'h13;
  localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    PH_READY   = 3'd0,
    PH_UNLOCK1 = 3'd1,
    PH_UNLOCK2 = 3'd2,
    PH_ERASE   = 3'd3,
    PH_PROGRAM = 3'd4,
    PH_BANK    = 3'd5
  } pfc_phase_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_READ  = 2'd2,
    ST_SWEEP = 2'd3
  } pfc_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_rd;
    logic sweep_en;
  } pfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic erase_go;
    logic sweep_last;
  } pfc_status_t;

endpackage

### design/pfc_ram.sv
module pfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/pfc_ctrl.sv
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        opcode_i,
  input  pfc_status_t status_i,
  output logic        in_ready_o,
  output pfc_cmd_t    cmd_o
);

  pfc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free) begin
          if (opcode_i == OP_READ) begin
            state_d = ST_READ;
          end else if (status_i.erase_go) begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.load_rd   = 1'b0;
    cmd_o.sweep_en  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = status_i.out_free;
        cmd_o.accept = in_valid_i && status_i.out_free;
      end
      ST_READ: begin
        cmd_o.load_rd = 1'b1;
      end
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### design/pfc_dp.sv
module pfc_dp
  import pfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [23:0]       in_data_i,
  input  logic              opcode_i,
  input  pfc_cmd_t          cmd_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] out_data_o,
  output logic              out_dirty_o,
  output pfc_status_t       status_o
);

  logic              large_q;
  pfc_phase_e        phase_q, phase_d;
  logic              ident_q, ident_d;
  logic              bank_q, bank_d;
  logic              mod_q, mod_d;
  logic [STORE_AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [STORE_AW-1:0] sweep_end_q, sweep_end_d;
  logic              id_hit_q;
  logic [DATA_W-1:0] id_byte_q;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_dirty_q, out_dirty_d;

  logic [ADDR_W-1:0]   addr_in;
  logic [DATA_W-1:0]   wdata;
  logic [BANK_AW-1:0]  addr_loc;
  logic [ADDR_W-1:0]   addr16;
  logic [BANK_AW:0]    idx_wide;
  logic [STORE_AW-1:0] idx;
  logic                sect_aligned;
  logic                chip_hit;
  logic                sect_hit;
  logic                wr;
  logic                prog_we;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;
  logic                id_hit;
  logic [DATA_W-1:0]   id_byte;

  assign addr_in  = in_data_i[ADDR_W-1:0];
  assign wdata    = in_data_i[ADDR_W +: DATA_W];
  assign addr_loc = addr_in[BANK_AW-1:0];
  assign addr16   = ADDR_W'(addr_loc);
  assign idx_wide = {bank_q & BANK_MASK, addr_loc};
  assign idx      = idx_wide[STORE_AW-1:0];

  assign sect_aligned = ((32'(addr16) & (SECTOR_BYTES - 1)) == 32'd0);
  assign chip_hit = (addr16 == ADDR_CMD) && (wdata == CMD_CHIP_ERS);
  assign sect_hit = sect_aligned && (wdata == CMD_SECT_ERS);
  assign wr       = cmd_i.accept && (opcode_i == OP_WRITE);

  assign status_o.erase_go   = (opcode_i == OP_WRITE) && (phase_q == PH_ERASE)
                               && (chip_hit || sect_hit);
  assign status_o.sweep_last = (sweep_addr_q == sweep_end_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // command sequence decoder
  always_comb begin
    phase_d      = phase_q;
    ident_d      = ident_q;
    bank_d       = bank_q;
    mod_d        = mod_q;
    prog_we      = 1'b0;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    if (cmd_i.sweep_en) begin
      sweep_addr_d = sweep_addr_q + 1'b1;
    end
    if (wr) begin
      if (addr16 == ADDR_CMD && wdata == DATA_UNLOCK1 && phase_q == PH_READY) begin
        phase_d = PH_UNLOCK1;
      end else if (addr16 == ADDR_UNLOCK && wdata == DATA_UNLOCK2
                   && phase_q == PH_UNLOCK1) begin
        phase_d = PH_UNLOCK2;
      end else if (addr16 == ADDR_CMD && phase_q == PH_UNLOCK2) begin
        phase_d = PH_READY;
        case (wdata)
          CMD_ID_ENTER: ident_d = 1'b1;
          CMD_ID_EXIT:  ident_d = 1'b0;
          CMD_ERASE:    phase_d = PH_ERASE;
          CMD_PROGRAM:  phase_d = PH_PROGRAM;
          CMD_BANK: begin
            if (large_q) begin
              phase_d = PH_BANK;
            end
          end
          default: phase_d = PH_READY;
        endcase
      end else if (phase_q == PH_ERASE && chip_hit) begin
        mod_d        = 1'b1;
        phase_d      = PH_READY;
        sweep_addr_d = '0;
        sweep_end_d  = large_q ? CHIP_LAST_L : CHIP_LAST_S;
      end else if (phase_q == PH_ERASE && sect_hit) begin
        mod_d        = 1'b1;
        phase_d      = PH_READY;
        sweep_addr_d = idx;
        sweep_end_d  = idx + SECT_LAST;
      end else if (phase_q == PH_PROGRAM) begin
        prog_we = 1'b1;
        mod_d   = 1'b1;
        phase_d = PH_READY;
      end else if (phase_q == PH_BANK && addr16 == ADDR_BANK) begin
        bank_d  = wdata[0];
        phase_d = PH_READY;
      end
    end
  end

  // id bytes, decided at accept since reads change nothing
  always_comb begin
    id_hit  = ident_q && (addr16 == ADDR_ID_MFR || addr16 == ADDR_ID_DEV);
    if (addr16 == ADDR_ID_MFR) begin
      id_byte = large_q ? ID_MFR_L : ID_MFR_S;
    end else begin
      id_byte = large_q ? ID_DEV_L : ID_DEV_S;
    end
  end

  assign ram_we    = cmd_i.sweep_en || prog_we;
  assign ram_waddr = cmd_i.sweep_en ? sweep_addr_q : idx;
  assign ram_wdata = cmd_i.sweep_en ? ERASED_BYTE : wdata;

  pfc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_dirty_d = out_dirty_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (wr) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_dirty_d = mod_d;
    end else if (cmd_i.load_rd) begin
      out_valid_d = 1'b1;
      out_data_d  = id_hit_q ? id_byte_q : ram_rdata;
      out_dirty_d = mod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_q      <= 1'b0;
      phase_q      <= PH_READY;
      ident_q      <= 1'b0;
      bank_q       <= 1'b0;
      mod_q        <= 1'b0;
      sweep_addr_q <= '0;
      sweep_end_q  <= STORE_LAST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        large_q <= cfg_wdata_i;
      end
      phase_q      <= phase_d;
      ident_q      <= ident_d;
      bank_q       <= bank_d;
      mod_q        <= mod_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_dirty_q <= out_dirty_d;
    if (cmd_i.accept) begin
      id_hit_q  <= id_hit;
      id_byte_q <= id_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_dirty_o = out_dirty_q;

endmodule

### design/parallel_flash_command_controller.sv
// channel | direction | tdata (low bit up)                 | tuser
// s_axis  | in        | address[15:0], write_data[23:16]   | opcode (0 read, 1 write)
// m_axis  | out       | read_data[7:0]                     | dirty
// cfg     | in        | large_size on cfg_wdata_i          | -
//
// a write's result is registered at the accepting edge
// a read passes through the registered read port of the byte store, then the output register
// an erase holds s_axis_tready low while it walks the store one byte a cycle:
//   4096 bytes for a sector, 65536 (small) or 131072 (large) bytes for the chip
// after reset a clearing pass fills all 131072 bytes of the store with 0xFF
// a new word is taken only when the output register is empty or being drained
module parallel_flash_command_controller
  import pfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: large_size
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
  input  logic        s_axis_tuser,   // opcode
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_data[7:0]
  output logic        m_axis_tuser    // dirty
);

  pfc_cmd_t    cmd;
  pfc_status_t status;

  // sequencer: clearing pass, accept, read wait, erase walk
  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // command decoder, byte store, erase counter and output register
  pfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .opcode_i    (s_axis_tuser),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_dirty_o (m_axis_tuser),
    .status_o    (status)
  );

endmodule

### design/pfc_checker.sv
module pfc_checker
  import pfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  logic in_hs;
  logic out_hs;
  logic pend_q;
  logic last_op_q;
  logic seen_dirty_q;

  assign in_hs  = s_axis_tvalid && s_axis_tready;
  assign out_hs = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      last_op_q    <= OP_READ;
      seen_dirty_q <= 1'b0;
    end else begin
      if (in_hs) begin
        pend_q    <= 1'b1;
        last_op_q <= s_axis_tuser;
      end else if (out_hs) begin
        pend_q <= 1'b0;
      end
      if (out_hs && m_axis_tuser) begin
        seen_dirty_q <= 1'b1;
      end
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // every result belongs to an accepted word
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q)
    else $error("result word without an accepted input word");

  // writes return zero data
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && last_op_q == OP_WRITE |-> m_axis_tdata == 8'h00)
    else $error("write result carries nonzero data");

  // the dirty mark never clears until reset
  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && seen_dirty_q |-> m_axis_tuser)
    else $error("dirty mark dropped");

endmodule

bind parallel_flash_command_controller pfc_checker u_pfc_checker (.*);

### verif/tb.sv
module tb;
  import pfc_pkg::*;

  // run limit: clearing pass, a few chip erases, a few dozen sector erases and
  // about 1400 words with stalls stay well under CYCLE_LIMIT
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_GAP  = 64;
  localparam int unsigned MAX_PRINTS  = 40;

  // one bus access as it travels on s_axis
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } flash_word_t;

  // one result word as it travels on m_axis
  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              dirty;
  } flash_result_t;

  // command-side state of the chip, shared by the stimulus shaper and the predictor
  typedef struct packed {
    pfc_phase_e phase;
    logic       id_on;
    logic       bank;
    logic       large_sz;
  } cmd_state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PROGRAM,
    ACT_CHIP_ERASE,
    ACT_SECT_ERASE
  } store_act_e;

  typedef struct packed {
    cmd_state_t nxt;
    store_act_e act;
  } cmd_step_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_wdata_i   = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;   // address[15:0], write_data[23:16]
  logic              s_axis_tuser  = 1'b0; // opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;         // read_data[7:0]
  logic              m_axis_tuser;         // dirty

  always #1 clk_i = ~clk_i;

  parallel_flash_command_controller u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  flash_word_t   words_to_send[$];     // filled by the stimulus, drained by the driver
  flash_result_t pending_results[$];   // expected result words, oldest first
  flash_word_t   cur_word;             // word currently offered on s_axis
  bit            word_taken  = 1'b0;   // set at the edge that accepted cur_word
  int unsigned   cycle_cnt   = 0;
  int unsigned   fail_count  = 0;
  int unsigned   results_seen = 0;
  // the block sweeps the whole store after reset, then the erased range on every erase
  int unsigned   busy_until  = STORE_BYTES + SETTLE_GAP;

  // predictor copy of the chip
  cmd_state_t    pred_ctl    = '0;
  logic          dirty_mark  = 1'b0;
  logic [7:0]    flash_img [STORE_BYTES];

  // stimulus-side copy of the command state, used only to shape the sequences
  cmd_state_t    gen_ctl     = '0;
  int unsigned   words_queued = 0;
  int unsigned   erase_left  = 28;     // entries into the erase phase
  int unsigned   chip_left   = 3;      // whole-chip sweeps are the expensive ones
  logic [15:0]   prog_addrs[$];        // recently programmed addresses, for read-back

  // sender burst and gap counters, receiver stall pattern
  int unsigned   burst_left  = 0;
  int unsigned   gap_left    = 0;
  int unsigned   stall_left  = 0;
  int unsigned   stall_mode  = 0;

  // ---------------------------------------------------------------------------
  // command sequencer: next state and the store action a write causes
  // ---------------------------------------------------------------------------
  function automatic cmd_step_t advance_cmd(cmd_state_t c, logic op, logic [15:0] a,
                                            logic [7:0] v);
    cmd_step_t s;
    s.nxt = c;
    s.act = ACT_NONE;
    if (op == OP_WRITE) begin
      if (a == ADDR_CMD && v == DATA_UNLOCK1 && c.phase == PH_READY) begin
        s.nxt.phase = PH_UNLOCK1;
      end else if (a == ADDR_UNLOCK && v == DATA_UNLOCK2 && c.phase == PH_UNLOCK1) begin
        s.nxt.phase = PH_UNLOCK2;
      end else if (a == ADDR_CMD && c.phase == PH_UNLOCK2) begin
        // third step always leaves the unlock phase, unknown codes included
        s.nxt.phase = PH_READY;
        case (v)
          CMD_ID_ENTER: s.nxt.id_on = 1'b1;
          CMD_ID_EXIT:  s.nxt.id_on = 1'b0;
          CMD_ERASE:    s.nxt.phase = PH_ERASE;
          CMD_PROGRAM:  s.nxt.phase = PH_PROGRAM;
          CMD_BANK:     if (c.large_sz) s.nxt.phase = PH_BANK;
          default: ;
        endcase
      end else if (c.phase == PH_ERASE && a == ADDR_CMD && v == CMD_CHIP_ERS) begin
        s.act       = ACT_CHIP_ERASE;
        s.nxt.phase = PH_READY;
      end else if (c.phase == PH_ERASE && (a % SECTOR_BYTES) == 0 && v == CMD_SECT_ERS) begin
        s.act       = ACT_SECT_ERASE;
        s.nxt.phase = PH_READY;
      end else if (c.phase == PH_PROGRAM) begin
        s.act       = ACT_PROGRAM;
        s.nxt.phase = PH_READY;
      end else if (c.phase == PH_BANK && a == ADDR_BANK) begin
        s.nxt.bank  = v[0];
        s.nxt.phase = PH_READY;
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: runs on every accepted word, queues the result it must produce
  // ---------------------------------------------------------------------------
  task automatic predict_flash_word(input flash_word_t w);
    cmd_step_t     s;
    flash_result_t r;
    int unsigned   base;
    int unsigned   lo;
    int unsigned   hi;
    base = (pred_ctl.bank & BANK_MASK) * BANK_BYTES;
    r.rd = '0;
    if (w.op == OP_READ) begin
      // id bytes only at the two id addresses, everything else reads the store
      if (pred_ctl.id_on && w.addr == ADDR_ID_MFR)
        r.rd = pred_ctl.large_sz ? ID_MFR_L : ID_MFR_S;
      else if (pred_ctl.id_on && w.addr == ADDR_ID_DEV)
        r.rd = pred_ctl.large_sz ? ID_DEV_L : ID_DEV_S;
      else
        r.rd = flash_img[base + w.addr];
    end else begin
      s = advance_cmd(pred_ctl, w.op, w.addr, w.data);
      case (s.act)
        ACT_PROGRAM: begin
          flash_img[base + w.addr] = w.data;
          dirty_mark = 1'b1;
        end
        ACT_CHIP_ERASE: begin
          hi = pred_ctl.large_sz ? CHIP_LEN_L : CHIP_LEN_S;
          for (lo = 0; lo < hi; lo++) flash_img[lo] = ERASED_BYTE;
          dirty_mark = 1'b1;
          busy_until = cycle_cnt + hi + SETTLE_GAP;
        end
        ACT_SECT_ERASE: begin
          // sector of the current bank, clipped at the bank end
          hi = base + w.addr + SECTOR_BYTES;
          if (hi > base + BANK_BYTES) hi = base + BANK_BYTES;
          for (lo = base + w.addr; lo < hi; lo++) flash_img[lo] = ERASED_BYTE;
          dirty_mark = 1'b1;
          busy_until = cycle_cnt + SECTOR_BYTES + SETTLE_GAP;
        end
        default: ;
      endcase
      pred_ctl = s.nxt;
    end
    r.dirty = dirty_mark;
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS)
      $display("mismatch at cycle %0d, result %0d: %s", cycle_cnt, results_seen, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: cycle count, timeout, config tracking and word acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_we_i) pred_ctl.large_sz = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_flash_word(cur_word);
        word_taken = 1'b1;
      end
    end
  end

  // driver: offers the next queued word in bursts, with random gaps between
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        cur_word = words_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_word.data, cur_word.addr};
        s_axis_tuser  <= cur_word.op;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // some bursts run back to back with no gap at all
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode after a random hold count
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: every result word against the oldest expectation
  always @(posedge clk_i) begin
    flash_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.rd)
          report_mismatch($sformatf("read_data %02h, expected %02h", m_axis_tdata, want.rd));
        if (m_axis_tuser !== want.dirty)
          report_mismatch($sformatf("dirty %0b, expected %0b", m_axis_tuser, want.dirty));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // queues one word; keeps the number of costly erases bounded
  task automatic push_word(input logic op, input logic [15:0] a, input logic [7:0] v);
    cmd_step_t   s;
    flash_word_t w;
    s = advance_cmd(gen_ctl, op, a, v);
    if (s.nxt.phase == PH_ERASE && gen_ctl.phase != PH_ERASE) begin
      // out of erase budget: turn the command into an unknown code
      if (erase_left == 0) begin
        v = 8'h00;
        s = advance_cmd(gen_ctl, op, a, v);
      end else begin
        erase_left--;
      end
    end else if (s.act == ACT_CHIP_ERASE) begin
      if (chip_left == 0) begin
        v = 8'h00;
        s = advance_cmd(gen_ctl, op, a, v);
      end else begin
        chip_left--;
      end
    end
    if (s.act == ACT_PROGRAM) begin
      if (prog_addrs.size() >= 64) void'(prog_addrs.pop_front());
      prog_addrs.push_back(a);
    end
    gen_ctl = s.nxt;
    w.op    = op;
    w.addr  = a;
    w.data  = v;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic unlock_cmd(input logic [7:0] cmd);
    push_word(OP_WRITE, ADDR_CMD, DATA_UNLOCK1);
    push_word(OP_WRITE, ADDR_UNLOCK, DATA_UNLOCK2);
    push_word(OP_WRITE, ADDR_CMD, cmd);
  endtask

  // read-back targets: programmed bytes, id addresses, or anywhere
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 3))
      0, 1: if (prog_addrs.size() != 0) return prog_addrs[$urandom_range(0, prog_addrs.size() - 1)];
      2: return 16'($urandom_range(0, 1));
      default: ;
    endcase
    return 16'($urandom());
  endfunction

  // waits for the block to drain and finish any sweep
  task automatic wait_quiet();
    @(posedge clk_i);
    while (words_to_send.size() != 0 || s_axis_tvalid || pending_results.size() != 0 ||
           cycle_cnt < busy_until)
      @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic set_chip_size(input logic big);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= big;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    gen_ctl.large_sz = big;
  endtask

  // mostly well-formed command sequences with random content, plus broken ones and noise
  task automatic random_phase(input int unsigned n);
    int unsigned stop;
    int unsigned sel;
    stop = words_queued + n;
    while (words_queued < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        unlock_cmd(CMD_PROGRAM);
        push_word(OP_WRITE, pick_addr(), 8'($urandom()));
      end else if (sel < 50) begin
        repeat ($urandom_range(1, 4)) push_word(OP_READ, pick_addr(), 8'($urandom()));
      end else if (sel < 57) begin
        unlock_cmd($urandom_range(0, 1) ? CMD_ID_ENTER : CMD_ID_EXIT);
        push_word(OP_READ, 16'($urandom_range(0, 1)), 8'($urandom()));
      end else if (sel < 63) begin
        unlock_cmd(CMD_BANK);
        // a bank byte away from address 0 must not be taken
        if ($urandom_range(0, 1))
          push_word(OP_WRITE, 16'($urandom_range(1, 65535)), 8'($urandom()));
        push_word(OP_WRITE, ADDR_BANK, 8'($urandom()));
      end else if (sel < 69) begin
        unlock_cmd(CMD_ERASE);
        if ($urandom_range(0, 7) == 0)
          push_word(OP_WRITE, ADDR_CMD, CMD_CHIP_ERS);
        else
          push_word(OP_WRITE, {4'($urandom()), 12'h000}, CMD_SECT_ERS);
      end else if (sel < 84) begin
        case ($urandom_range(0, 2))
          0: begin
            // wrong second step, phase must hold
            push_word(OP_WRITE, ADDR_CMD, DATA_UNLOCK1);
            push_word(OP_WRITE, 16'($urandom()), 8'($urandom()));
          end
          1: begin
            // third step with an arbitrary code
            push_word(OP_WRITE, ADDR_CMD, DATA_UNLOCK1);
            push_word(OP_WRITE, ADDR_UNLOCK, DATA_UNLOCK2);
            push_word(OP_WRITE, ADDR_CMD, 8'($urandom()));
          end
          default: begin
            // third step at a wrong address, with a read in between
            push_word(OP_WRITE, ADDR_CMD, DATA_UNLOCK1);
            push_word(OP_WRITE, ADDR_UNLOCK, DATA_UNLOCK2);
            push_word(OP_READ, pick_addr(), 8'($urandom()));
            push_word(OP_WRITE, 16'($urandom()), 8'($urandom()));
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 3))
          push_word(1'($urandom()), ($urandom_range(0, 7) == 0) ? ADDR_CMD : 16'($urandom()),
                    8'($urandom()));
      end
      // never leave the chip waiting in the erase phase
      if (gen_ctl.phase == PH_ERASE)
        push_word(OP_WRITE, {4'($urandom()), 12'h000}, CMD_SECT_ERS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < STORE_BYTES; i++) flash_img[i] = ERASED_BYTE;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // small chip: erased read, reads inside a sequence, id bytes, program at
    // the top address, bank command ignored, whole-chip erase
    set_chip_size(1'b0);
    push_word(OP_READ, 16'h0000, 8'h00);
    push_word(OP_WRITE, ADDR_CMD, DATA_UNLOCK1);
    push_word(OP_READ, 16'hFFFF, 8'hFF);
    push_word(OP_WRITE, ADDR_UNLOCK, DATA_UNLOCK2);
    push_word(OP_WRITE, ADDR_CMD, CMD_ID_ENTER);
    push_word(OP_READ, ADDR_ID_MFR, 8'h00);
    push_word(OP_READ, ADDR_ID_DEV, 8'h00);
    unlock_cmd(CMD_PROGRAM);
    push_word(OP_WRITE, 16'hFFFF, 8'h00);
    push_word(OP_READ, 16'hFFFF, 8'h00);
    unlock_cmd(CMD_BANK);
    unlock_cmd(CMD_ERASE);
    push_word(OP_WRITE, ADDR_CMD, CMD_CHIP_ERS);
    push_word(OP_READ, 16'hFFFF, 8'h00);

    // large chip: id bytes change, bank byte ignored off address 0, only bit 0
    // of 0xFF kept, then a two-bank chip erase
    set_chip_size(1'b1);
    push_word(OP_READ, ADDR_ID_MFR, 8'h00);
    push_word(OP_READ, ADDR_ID_DEV, 8'h00);
    unlock_cmd(CMD_BANK);
    push_word(OP_WRITE, 16'h1234, 8'h01);
    push_word(OP_WRITE, ADDR_BANK, 8'hFF);
    unlock_cmd(CMD_ERASE);
    push_word(OP_WRITE, ADDR_CMD, CMD_CHIP_ERS);

    // random part; the first small phase starts with bank 1 still selected
    chip_left = (chip_left > 1) ? 1 : chip_left;
    for (int p = 0; p < 4; p++) begin
      set_chip_size(p[0]);
      random_phase(350);
    end

    wait_quiet();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
